// ----- rtl/adnlp_pkg.sv -----
// ----------------------------------------------------------------------------
// adnlp_pkg
// Shared constants, payload types and control structs of the adaptive-degree
// next-line prefetcher.
// ----------------------------------------------------------------------------
package adnlp_pkg;

  // Geometry
  localparam int MAX_DEG    = 16;
  localparam int LINE_BYTES = 64;    // power of two
  localparam int PAGE_BITS  = 12;

  localparam int LINE_SHIFT = $clog2(LINE_BYTES);
  localparam int ROOM_W     = PAGE_BITS - LINE_SHIFT;
  localparam int DEG_W      = $clog2(MAX_DEG + 1);
  localparam int CMP_W      = (ROOM_W > DEG_W) ? ROOM_W : DEG_W;

  // Field widths
  localparam int ADDR_W = 64;
  localparam int META_W = 32;
  localparam int RET_W  = 64;
  localparam int WIN_W  = 32;
  localparam int ACC_W  = 10;
  localparam int MISS_W = 32;
  localparam int RATE_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // MPKI in Q22.10: misses * 1000 * 1024 / instructions
  localparam int RATE_SCALE = 1024000;
  localparam int SCALE_W    = $clog2(RATE_SCALE + 1);
  localparam int NUM_W      = MISS_W + SCALE_W;
  localparam int DCNT_W     = $clog2(NUM_W + 1);

  // Decoupling queue
  localparam int QDEPTH = 4;   // power of two
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Opcodes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_WIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE      = 2'd2;

  // Register reset values
  localparam logic [WIN_W-1:0] SWEEP_WIN_RST = 32'd5000;
  localparam logic [WIN_W-1:0] HOLD_WIN_RST  = 32'd25000;
  localparam logic [ACC_W-1:0] GATE_RST      = 10'd10;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] access_addr;
    logic              hit;
    logic [META_W-1:0] meta_in;
    logic [RET_W-1:0]  retired_count;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefetch_addr;
    logic [META_W-1:0] meta_out;
    logic              last;
  } out_item_t;

  // One queued access for the issue side
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [META_W-1:0] meta;
    logic [DEG_W-1:0]  deg;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [MISS_W-1:0] misses;
    logic [RET_W-1:0]  elapsed;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] rate;
  } div_rsp_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV_WAIT,
    F_SEARCH
  } front_state_t;

endpackage

// ----- rtl/adaptive_degree_next_line_prefetcher.sv -----
// ----------------------------------------------------------------------------
// adaptive_degree_next_line_prefetcher
// Next-line prefetcher whose degree is picked by sweeping every degree and
// keeping the one with the lowest misses per kilo-instruction.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+-------------------------------
//   in      | in_valid  | in_ready  | in_item  (access or tick)
//   out     | out_valid | out_ready | out_item (one prefetch beat)
//   cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// An access is accepted when the front is idle and the queue has room; the
// issue side loads it from the queue and then sends one prefetch beat per
// cycle (0..16) while the receiver is ready. A tick that closes a sweep window
// holds the front for the rate divide (one quotient bit a cycle) and, after the
// last degree, for the min search. Synchronous reset; no clearing pass.
// Front and issue side stall independently through a four-entry queue.
// ----------------------------------------------------------------------------
module adaptive_degree_next_line_prefetcher (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  adnlp_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output adnlp_pkg::out_item_t              out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adnlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adnlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import adnlp_pkg::*;

  logic     push, pop, q_full, q_empty;
  job_t     push_job, head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  adnlp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  adnlp_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  adnlp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  adnlp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

// ----- rtl/adnlp_div.sv -----
// ----------------------------------------------------------------------------
// adnlp_div
// Miss-rate unit: scales the miss count, then restoring divide by the elapsed
// instruction count, one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module adnlp_div (
  input  logic                clk,
  input  logic                rst,
  input  adnlp_pkg::div_req_t req,
  output adnlp_pkg::div_rsp_t rsp
);
  import adnlp_pkg::*;

  logic [NUM_W-1:0]  num;      // dividend, shifts out as quotient shifts in
  logic [RET_W-1:0]  den;
  logic [RET_W-1:0]  rem;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [RET_W:0] rem_sh;
  logic           ge;

  assign rem_sh = {rem, num[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= NUM_W'(req.misses) * NUM_W'(RATE_SCALE);
      den <= req.elapsed;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? RET_W'(rem_sh - {1'b0, den}) : rem_sh[RET_W-1:0];
      num <= {num[NUM_W-2:0], ge};
    end
  end

  // zero divisor gives an all-ones quotient, which saturates as required
  assign rsp.done = done;
  assign rsp.rate = (num[NUM_W-1:RATE_W] != '0) ? RATE_MAX : num[RATE_W-1:0];

`ifndef SYNTHESIS
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider running with empty count");
`endif

endmodule

// ----- rtl/adnlp_front.sv -----
// ----------------------------------------------------------------------------
// adnlp_front
// Accepts items, keeps counters, windows and the degree sweep, and queues
// accesses with the degree in force for the issue side.
// ----------------------------------------------------------------------------
module adnlp_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  adnlp_pkg::in_item_t                in_item,
  input  logic                               cfg_valid,
  input  logic [adnlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adnlp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                               push,
  output adnlp_pkg::job_t                    push_job,
  input  logic                               q_full,
  output adnlp_pkg::div_req_t                div_req,
  input  adnlp_pkg::div_rsp_t                div_rsp
);
  import adnlp_pkg::*;

  front_state_t state, state_next;

  logic [WIN_W-1:0]  sweep_window_instr;
  logic [WIN_W-1:0]  hold_window_instr;
  logic [ACC_W-1:0]  access_gate;

  logic [ACC_W-1:0]  access_count;
  logic [MISS_W-1:0] miss_count;
  logic [RET_W-1:0]  window_start;
  logic [DEG_W-1:0]  current_degree;
  logic              hold_mode;
  logic [RATE_W-1:0] rate_table [MAX_DEG+1];

  logic [DEG_W-1:0]  search_idx;
  logic [DEG_W-1:0]  best;
  logic [RATE_W-1:0] best_rate;

  logic              acc_fire, tick_fire, gate_ok;
  logic [RET_W-1:0]  elapsed;
  logic              sweep_close, hold_close;
  logic              deg_is_max, idx_is_max, cand_lt;
  logic [RATE_W-1:0] cand;

  assign in_ready  = (state == F_IDLE) && !q_full;
  assign acc_fire  = in_valid && in_ready && (in_item.opcode == OP_ACCESS);
  assign tick_fire = in_valid && in_ready && (in_item.opcode == OP_TICK);
  assign gate_ok   = !(access_count < access_gate);
  assign elapsed   = in_item.retired_count - window_start;

  assign sweep_close = tick_fire && gate_ok && !hold_mode &&
                       !(elapsed < RET_W'(sweep_window_instr));
  assign hold_close  = tick_fire && gate_ok && hold_mode &&
                       !(elapsed < RET_W'(hold_window_instr));

  assign deg_is_max = current_degree == DEG_W'(MAX_DEG);
  assign idx_is_max = search_idx == DEG_W'(MAX_DEG);
  assign cand       = rate_table[search_idx];
  assign cand_lt    = cand < best_rate;

  assign push          = acc_fire;
  assign push_job.addr = in_item.access_addr;
  assign push_job.meta = in_item.meta_in;
  assign push_job.deg  = current_degree;

  assign div_req.start   = sweep_close;
  assign div_req.misses  = miss_count;
  assign div_req.elapsed = elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (sweep_close) state_next = F_DIV_WAIT;
      end
      F_DIV_WAIT: begin
        if (div_rsp.done) state_next = deg_is_max ? F_SEARCH : F_IDLE;
      end
      F_SEARCH: begin
        if (idx_is_max) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_window_instr <= SWEEP_WIN_RST;
      hold_window_instr  <= HOLD_WIN_RST;
      access_gate        <= GATE_RST;
      access_count       <= '0;
      miss_count         <= '0;
      window_start       <= '0;
      current_degree     <= '0;
      hold_mode          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SWEEP_WIN: sweep_window_instr <= cfg_data[WIN_W-1:0];
          CFG_HOLD_WIN:  hold_window_instr  <= cfg_data[WIN_W-1:0];
          CFG_GATE:      access_gate        <= cfg_data[ACC_W-1:0];
          default: ;
        endcase
      end

      if (acc_fire) begin
        if (access_count != ACC_MAX) access_count <= access_count + 1'b1;
        if (!in_item.hit && miss_count != MISS_MAX) miss_count <= miss_count + 1'b1;
      end

      if (tick_fire && gate_ok) access_count <= '0;

      if (sweep_close) begin
        window_start <= in_item.retired_count;
        miss_count   <= '0;
      end

      if (hold_close) begin
        window_start   <= in_item.retired_count;
        miss_count     <= '0;
        current_degree <= '0;
        hold_mode      <= 1'b0;
      end

      if (state == F_DIV_WAIT && div_rsp.done && !deg_is_max)
        current_degree <= current_degree + 1'b1;

      // last step of the search folds in the final candidate
      if (state == F_SEARCH && idx_is_max) begin
        current_degree <= cand_lt ? search_idx : best;
        hold_mode      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_DIV_WAIT && div_rsp.done) begin
      rate_table[current_degree] <= div_rsp.rate;
    end
  end

  // min search over the table, one entry a cycle, lowest index wins ties
  always_ff @(posedge clk) begin
    if (state == F_DIV_WAIT && div_rsp.done && deg_is_max) begin
      best       <= '0;
      best_rate  <= rate_table[0];
      search_idx <= DEG_W'(1);
    end else if (state == F_SEARCH) begin
      if (cand_lt) begin
        best      <= search_idx;
        best_rate <= cand;
      end
      search_idx <= search_idx + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == F_DIV_WAIT)
    else $error("rate result with no window close pending");

  a_search_idx: assert property (@(posedge clk) disable iff (rst)
    state == F_SEARCH |-> search_idx != '0 && search_idx <= DEG_W'(MAX_DEG))
    else $error("search index out of range");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    hold_mode |-> state == F_IDLE)
    else $error("hold mode while sweep work in flight");
`endif

endmodule

// ----- rtl/adnlp_fifo.sv -----
// ----------------------------------------------------------------------------
// adnlp_fifo
// Short queue of accepted accesses between the front and the issue side.
// ----------------------------------------------------------------------------
module adnlp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  adnlp_pkg::job_t push_job,
  input  logic            pop,
  output adnlp_pkg::job_t head,
  output logic            full,
  output logic            empty
);
  import adnlp_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QDEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");
`endif

endmodule

// ----- rtl/adnlp_back.sv -----
// ----------------------------------------------------------------------------
// adnlp_back
// Issue side: turns a queued access into its run of next-line prefetches,
// clipped at page end, one registered beat per cycle while out_ready holds.
// ----------------------------------------------------------------------------
module adnlp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  adnlp_pkg::job_t      head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output adnlp_pkg::out_item_t out_item
);
  import adnlp_pkg::*;

  logic              busy;
  logic [ADDR_W-1:0] cur_addr;
  logic [META_W-1:0] meta;
  logic [DEG_W-1:0]  rem;

  logic [PAGE_BITS-1:0] off_inv;
  logic [ROOM_W-1:0]    room;      // whole lines left in the page
  logic [CMP_W-1:0]     room_ext, deg_ext, count_sel;
  logic [ADDR_W-1:0]    next_addr;
  logic                 load_out;

  assign off_inv   = ~head.addr[PAGE_BITS-1:0];
  assign room      = off_inv[PAGE_BITS-1:LINE_SHIFT];
  assign room_ext  = CMP_W'(room);
  assign deg_ext   = CMP_W'(head.deg);
  assign count_sel = (room_ext < deg_ext) ? room_ext : deg_ext;

  assign pop       = !busy && !q_empty;
  assign load_out  = busy && (!out_valid || out_ready);
  assign next_addr = cur_addr + ADDR_W'(LINE_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= count_sel != '0;
      end else if (load_out && rem == DEG_W'(1)) begin
        busy <= 1'b0;
      end
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr <= head.addr;
      meta     <= head.meta;
      rem      <= DEG_W'(count_sel);
    end else if (load_out) begin
      cur_addr <= next_addr;
      rem      <= rem - 1'b1;
    end
    if (load_out) begin
      out_item.prefetch_addr <= next_addr;
      out_item.meta_out      <= meta;
      out_item.last          <= rem == DEG_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem != '0)
    else $error("issue side busy with nothing left to send");
`endif

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adaptive-degree next-line prefetcher. Directed
// tasks cover reset register values, page and address-space edges, the open
// access gate and window extremes. A random phase then runs well-formed
// sweep/hold rounds mixed with short and stale rounds. An in-bench predictor
// of degree, windows and rates supplies the expected prefetch beats, which are
// checked in order as they leave the block.
// ----------------------------------------------------------------------------
module testbench;
  import adnlp_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no beat on any channel
  localparam int SETTLE_CYCLES = 100;   // covers a rate divide plus min search
  localparam int RAND_ITEMS    = 55;
  localparam int PHASE_ITEMS   = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  adaptive_degree_next_line_prefetcher u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [WIN_W-1:0]  sweep_win_q = SWEEP_WIN_RST;
  logic [WIN_W-1:0]  hold_win_q  = HOLD_WIN_RST;
  logic [ACC_W-1:0]  gate_q      = GATE_RST;
  logic [ACC_W-1:0]  acc_cnt     = '0;
  logic [MISS_W-1:0] miss_cnt    = '0;
  logic [RET_W-1:0]  win_start   = '0;
  logic [4:0]        cur_deg     = '0;
  logic              hold_q      = 1'b0;
  logic [RATE_W-1:0] mpki_tbl [0:MAX_DEG];

  out_item_t pending_prefetches[$];

  int n_access    = 0;
  int n_tick      = 0;
  int n_beats     = 0;
  int sweeps_done = 0;
  int holds_done  = 0;
  int mismatches  = 0;
  int burst_left  = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [RATE_W-1:0] mpki_q10(input logic [MISS_W-1:0] misses,
                                                 input logic [RET_W-1:0] elapsed);
    logic [63:0] q;
    if (elapsed == 0) return RATE_MAX;
    q = ({32'd0, misses} * 64'(RATE_SCALE)) / elapsed;
    if (q > 64'(RATE_MAX)) return RATE_MAX;
    return q[RATE_W-1:0];
  endfunction

  task automatic advance_degree_on_tick(input logic [RET_W-1:0] retired);
    logic [RET_W-1:0] elapsed;
    int best;
    int i;
    if (acc_cnt >= gate_q) begin
      acc_cnt = '0;
      elapsed = retired - win_start;
      if (!hold_q) begin
        if (elapsed >= 64'(sweep_win_q)) begin
          win_start = retired;
          mpki_tbl[cur_deg] = mpki_q10(miss_cnt, elapsed);
          miss_cnt = '0;
          cur_deg = cur_deg + 5'd1;
          if (cur_deg > MAX_DEG) begin
            // lowest rate wins, lowest degree on a tie
            best = 0;
            for (i = 1; i <= MAX_DEG; i++)
              if (mpki_tbl[i] < mpki_tbl[best]) best = i;
            cur_deg = best[4:0];
            hold_q = 1'b1;
            sweeps_done++;
          end
        end
      end else if (elapsed >= 64'(hold_win_q)) begin
        win_start = retired;
        miss_cnt = '0;
        cur_deg = '0;
        hold_q = 1'b0;
        holds_done++;
      end
    end
  endtask

  task automatic predict_prefetches(input in_item_t it);
    out_item_t beat;
    logic [ADDR_W-1:0] pf;
    int k;
    int n;
    if (acc_cnt != ACC_MAX) acc_cnt = acc_cnt + 1'b1;
    if (!it.hit && miss_cnt != MISS_MAX) miss_cnt = miss_cnt + 1'b1;
    n = 0;
    for (k = 1; k <= cur_deg; k++) begin
      pf = it.access_addr + 64'(k) * 64'(LINE_BYTES);
      // a wrapped line always lands in another page
      if (pf[ADDR_W-1:PAGE_BITS] != it.access_addr[ADDR_W-1:PAGE_BITS]) break;
      n = k;
    end
    for (k = 1; k <= n; k++) begin
      beat.prefetch_addr = it.access_addr + 64'(k) * 64'(LINE_BYTES);
      beat.meta_out      = it.meta_in;
      beat.last          = (k == n);
      pending_prefetches.push_back(beat);
    end
  endtask

  // ----------------------------------------------------------------- drivers
  task automatic send_beat(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.opcode == OP_TICK) begin
      n_tick++;
      advance_degree_on_tick(it.retired_count);
    end else begin
      n_access++;
      predict_prefetches(it);
    end
  endtask

  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic hit,
                             input logic [META_W-1:0] meta);
    in_item_t it;
    it.opcode        = OP_ACCESS;
    it.access_addr   = addr;
    it.hit           = hit;
    it.meta_in       = meta;
    it.retired_count = {$urandom, $urandom};   // ignored on an access
    send_beat(it);
  endtask

  task automatic send_tick(input logic [RET_W-1:0] retired);
    in_item_t it;
    it.opcode        = OP_TICK;
    it.access_addr   = {$urandom, $urandom};
    it.hit           = 1'($urandom_range(0, 1));
    it.meta_in       = $urandom;
    it.retired_count = retired;
    send_beat(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SWEEP_WIN: sweep_win_q = data;
      CFG_HOLD_WIN:  hold_win_q  = data;
      CFG_GATE:      gate_q      = data[ACC_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic park_input();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_prefetches_done();
    while (pending_prefetches.size() != 0) @(posedge clk);
  endtask

  // idle point: all beats out and any divide or search finished
  task automatic quiesce();
    park_input();
    wait_prefetches_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: a[PAGE_BITS-1:0] = '0;
      2, 3: a[PAGE_BITS-1:0] = PAGE_BITS'((1 << PAGE_BITS) - 1 - $urandom_range(0, 20 * LINE_BYTES));
      7:    a = '1 - 64'($urandom_range(0, 20 * LINE_BYTES));
      default: ;
    endcase
    return a;
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_default_regs();
    int k;
    send_access(64'h0, 1'b1, 32'h0);
    send_access('1, 1'b0, '1);
    for (k = 0; k < 7; k++) send_access(pick_addr(), k[0], $urandom);
    send_tick(64'd20000);            // nine accesses: gated
    send_access(pick_addr(), 1'b0, $urandom);
    send_tick(64'd4999);             // gate open, window one short
    send_tick(64'd5000);             // counter was cleared: gated again
  endtask

  task automatic test_page_edges();
    quiesce();
    write_reg(CFG_GATE, 32'd1);
    write_reg(CFG_SWEEP_WIN, 32'd1);
    send_access(pick_addr(), 1'b0, $urandom);
    send_tick(64'd5000);                                  // degree 0 -> 1
    send_access(64'h0, 1'b1, 32'hFFFF_FFFF);
    send_access(64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 32'h0);    // next line wraps
    send_access(64'h0123_4567_89AB_CFBF, 1'b1, $urandom); // second-to-last line of page
    send_tick(win_start + 64'd1);
    send_access(64'hFEDC_BA98_7654_3F80, 1'b0, $urandom); // cut short at page
    send_access(64'h8000_0000_0000_0000, 1'b1, $urandom);
    send_tick(win_start + 64'd1);
  endtask

  task automatic test_zero_gate();
    quiesce();
    write_reg(CFG_GATE, 32'd0);
    while (cur_deg < MAX_DEG) send_tick(win_start + 64'd1);
    send_access(64'hAAAA_5555_AAAA_5000, 1'b1, $urandom);  // full degree
    send_access(64'h5555_AAAA_5555_AC00, 1'b1, $urandom);
    send_tick(win_start + 64'd1);                          // sweep ends, hold
  endtask

  task automatic test_window_limits();
    send_tick(win_start + 64'(HOLD_WIN_RST) - 64'd1);
    send_access(64'h0000_0000_1234_0000, 1'b0, $urandom);
    send_tick(win_start + 64'(HOLD_WIN_RST));              // back to sweep
    quiesce();
    write_reg(CFG_SWEEP_WIN, 32'hFFFF_FFFF);
    write_reg(CFG_HOLD_WIN, 32'hFFFF_FFFF);
    send_tick(win_start + 64'hFFFF_FFFE);
    send_tick(win_start + 64'hFFFF_FFFF);
    send_access(pick_addr(), 1'b0, $urandom);
    send_tick(win_start - 64'd1);                          // count went backward
  endtask

  task automatic run_round();
    int n_acc;
    int miss_pct;
    int k;
    logic [WIN_W-1:0] span;
    logic [RET_W-1:0] adv;
    miss_pct = $urandom_range(0, 100);
    if ($urandom_range(0, 9) == 0) send_tick(win_start + 64'd1);   // stray tick
    if (gate_q != 0 && $urandom_range(0, 6) == 0) n_acc = $urandom_range(0, gate_q - 1);
    else n_acc = gate_q + $urandom_range(0, 2);
    for (k = 0; k < n_acc; k++)
      send_access(pick_addr(), $urandom_range(1, 100) > miss_pct, $urandom);
    span = hold_q ? hold_win_q : sweep_win_q;
    case ($urandom_range(0, 9))
      0, 1:    adv = 64'($urandom_range(0, span - 1));
      2:       adv = 64'd0 - 64'($urandom_range(1, 1000));
      default: adv = 64'(span) + 64'($urandom_range(0, 40));
    endcase
    send_tick(win_start + adv);
  endtask

  task automatic test_random_traffic();
    int phase;
    int base_items;
    int phase_start;
    base_items = n_access + n_tick;
    phase = 0;
    while (phase < 16 && n_access + n_tick - base_items < RAND_ITEMS) begin
      quiesce();
      if (phase == 0) begin
        write_reg(CFG_SWEEP_WIN, 32'd1);
        write_reg(CFG_HOLD_WIN, 32'd1);
        write_reg(CFG_GATE, 32'd1);
      end else begin
        write_reg(CFG_SWEEP_WIN, $urandom_range(1, 100));
        write_reg(CFG_HOLD_WIN, $urandom_range(1, 300));
        write_reg(CFG_GATE, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4));
      end
      phase_start = n_access + n_tick;
      while (n_access + n_tick - phase_start < PHASE_ITEMS) begin
        run_round();
        if ($urandom_range(0, 19) == 0) begin
          park_input();
          wait_prefetches_done();
        end
      end
      phase++;
    end
  endtask

  // ----------------------------------------------------------------- checker
  out_item_t want_beat;

  task automatic flag_mismatch(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected addr=%h meta=%h last=%b, got addr=%h meta=%h last=%b", what,
               want.prefetch_addr, want.meta_out, want.last,
               got.prefetch_addr, got.meta_out, got.last);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_beats++;
      if (pending_prefetches.size() == 0) begin
        flag_mismatch("unexpected prefetch beat", '0, out_item);
      end else begin
        want_beat = pending_prefetches.pop_front();
        if (out_item.prefetch_addr !== want_beat.prefetch_addr ||
            out_item.meta_out !== want_beat.meta_out ||
            out_item.last !== want_beat.last)
          flag_mismatch("prefetch beat mismatch", want_beat, out_item);
      end
    end
  end

  // Receiver stalls on a rotating pattern, re-rolled when its run counter expires
  int          ready_left = 0;
  int          ready_mode = 0;
  logic [31:0] ready_pat  = '1;

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_pat  = $urandom | 32'h1;
      ready_left = $urandom_range(8, 64);
    end
    ready_left--;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ready_pat[0];
      2:       out_ready <= ready_pat[0] & ready_pat[1];
      default: out_ready <= |ready_pat[2:0];
    endcase
    ready_pat = {ready_pat[0], ready_pat[31:1]};
  end

  // ---------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAIL adaptive_degree_next_line_prefetcher");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------- main
  initial begin
    for (int i = 0; i <= MAX_DEG; i++) mpki_tbl[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_default_regs();
    test_page_edges();
    test_zero_gate();
    test_window_limits();
    test_random_traffic();
    quiesce();
    $display("ran %0d accesses and %0d ticks, checked %0d prefetch beats", n_access, n_tick,
             n_beats);
    $display("%0d degree sweeps finished, %0d hold windows expired, %0d mismatches",
             sweeps_done, holds_done, mismatches);
    if (mismatches == 0) begin
      $display("PASS adaptive_degree_next_line_prefetcher");
    end else begin
      $display("FAIL adaptive_degree_next_line_prefetcher");
    end
    $finish;
  end

endmodule
